FILE: hdl/pvpa_pkg.sv
// Shared types and constants for the point projection anchor.
package pvpa_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int IO_W           = 32;
  localparam int IDX_W          = 5;
  localparam int CFG_IDX_W      = 1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FEET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD = 1'b1;

  // Input command codes.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam int THRESH_DIV = 10000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;    // capture a project request
    logic       mac_clr;  // clear the accumulator
    logic       mac_en;   // accumulate one product
    logic       mac_mul;  // register one vector element
    logic [1:0] vsel;     // vector element index (row)
    logic [1:0] csel;     // output column
    logic       proj;     // 0 view pass, 1 projection pass
    logic       head;     // 0 feet point, 1 head point
    logic       col_st;   // store the finished column
    logic       div_go;   // start a division
    logic       div_y;    // 0 divide x, 1 divide y
    logic       div_st;   // store the quotient
    logic       fin;      // result ready to present
  } pvpa_cmd_t;

  typedef struct packed {
    logic div_done;
    logic w_ok;
  } pvpa_sts_t;

endpackage

FILE: hdl/pvpa_if.sv
// Valid/ready channel interface carrying a generic payload.
interface pvpa_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/pvpa_ctrl.sv
// Controller state machine that sequences the shared multiplier and divider.
module pvpa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic                  out_free,
  input  pvpa_pkg::pvpa_sts_t   sts,
  output pvpa_pkg::pvpa_cmd_t   cmd,
  output logic                  busy
);
  import pvpa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_COL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DWT  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] r, r_next, c, c_next;
  logic       p, p_next, h, h_next, dy, dy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r <= '0; c <= '0; p <= 1'b0; h <= 1'b0; dy <= 1'b0;
    end else begin
      state <= state_next;
      r <= r_next; c <= c_next; p <= p_next; h <= h_next; dy <= dy_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    r_next = r; c_next = c; p_next = p; h_next = h; dy_next = dy;
    cmd = '0;
    cmd.vsel = r; cmd.csel = c; cmd.proj = p; cmd.head = h; cmd.div_y = dy;
    case (state)
      S_IDLE: begin
        if (go) begin
          cmd.start = 1'b1;
          cmd.mac_clr = 1'b1;
          r_next = '0; c_next = '0; p_next = 1'b0; h_next = 1'b0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mac_mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.mac_en = 1'b1;
        r_next = r + 2'd1;
        state_next = (r == 2'd3) ? S_COL : S_MUL;
      end
      S_COL: begin
        cmd.col_st = 1'b1;
        cmd.mac_clr = 1'b1;
        c_next = c + 2'd1;
        state_next = S_MUL;
        if (c == 2'd3) begin
          if (!p) begin
            p_next = 1'b1;
          end else begin
            state_next = S_DIV;
            dy_next = 1'b0;
          end
        end
      end
      S_DIV: begin
        if (!sts.w_ok) begin
          state_next = S_OUT;
        end else begin
          cmd.div_go = 1'b1;
          state_next = S_DWT;
        end
      end
      S_DWT: begin
        if (sts.div_done) begin
          cmd.div_st = 1'b1;
          if (!dy) begin
            dy_next = 1'b1;
            state_next = S_DIV;
          end else if (!h) begin
            h_next = 1'b1; p_next = 1'b0; c_next = '0;
            cmd.mac_clr = 1'b1;
            state_next = S_MUL;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/pvpa_dp.sv
// Datapath: matrix memory, shared multiply-accumulate, serial divider, result holding.
module pvpa_dp #(
  parameter int FRAC_BITS  = pvpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = pvpa_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ld_en,
  input  logic [pvpa_pkg::IDX_W-1:0]    ld_idx,
  input  logic [pvpa_pkg::IO_W-1:0]     ld_word,
  input  logic                          cfg_we,
  input  logic [pvpa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pvpa_pkg::IO_W-1:0]     cfg_data,
  input  logic                          in_play,
  input  logic [pvpa_pkg::IO_W-1:0]     pos_x,
  input  logic [pvpa_pkg::IO_W-1:0]     pos_y,
  input  logic [pvpa_pkg::IO_W-1:0]     pos_z,
  input  pvpa_pkg::pvpa_cmd_t           cmd,
  output pvpa_pkg::pvpa_sts_t           sts,
  output logic                          res_valid,
  output logic [pvpa_pkg::IO_W-1:0]     res_fx,
  output logic [pvpa_pkg::IO_W-1:0]     res_fy,
  output logic [pvpa_pkg::IO_W-1:0]     res_hx,
  output logic [pvpa_pkg::IO_W-1:0]     res_hy
);
  import pvpa_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int PW = 2 * WORD_WIDTH;
  localparam int SW = WORD_WIDTH + 2;
  localparam int DW = WORD_WIDTH + FRAC_BITS + 1;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = W'(1) << FRAC_BITS;
  localparam logic signed [W-1:0] THR  = W'((64'd1 << FRAC_BITS) / THRESH_DIV);

  // Saturate a 32-bit signed value to the word range (extend if wider).
  function automatic logic signed [W-1:0] fit(input logic [IO_W-1:0] v);
    logic signed [PW-1:0] e;
    e = PW'($signed(v));
    if (e > PW'(WMAX)) return WMAX;
    if (e < PW'(WMIN)) return WMIN;
    return W'(e);
  endfunction

  // Saturate a word value to 32 bits on the way out.
  function automatic logic [IO_W-1:0] to32(input logic signed [W-1:0] v);
    logic signed [PW-1:0] e;
    e = PW'(v);
    if (e > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (e < -64'sh80000000) return 32'h80000000;
    return IO_W'(e);
  endfunction

  logic [IO_W-1:0] mem [32];
  logic [IO_W-1:0] mem_q;
  logic signed [W-1:0] feet_off, head_off;
  logic signed [W-1:0] px, py, pz;
  logic       play;
  logic signed [W-1:0] vin [4];
  logic signed [W-1:0] vout [4];
  logic signed [W-1:0] v_el, m_el, prod_sat;
  logic signed [PW-1:0] prod_full, prod_sh;
  logic signed [SW-1:0] acc;
  logic signed [W-1:0] acc_sat;
  logic signed [W-1:0] yl;
  logic signed [W:0]   ysum;
  logic [IDX_W-1:0] rd_addr;

  // Matrix memory, one write and one registered read port.
  assign rd_addr = {cmd.proj, cmd.vsel, cmd.csel};
  always_ff @(posedge clk) begin
    if (ld_en) mem[ld_idx] <= ld_word;
    mem_q <= mem[rd_addr];
  end

  // Offset registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      feet_off <= '0;
      head_off <= fit(IO_W'(9) << FRAC_BITS);
    end else if (cfg_we) begin
      if (cfg_idx == REG_FEET) feet_off <= fit(cfg_data);
      else head_off <= fit(cfg_data);
    end
  end

  // Lifted y for the current point.
  assign ysum = (W+1)'(py) + (W+1)'(cmd.head ? head_off : feet_off);
  always_comb begin
    if (ysum > (W+1)'(WMAX)) yl = WMAX;
    else if (ysum < (W+1)'(WMIN)) yl = WMIN;
    else yl = W'(ysum);
  end

  always_comb begin
    if (!cmd.proj) begin
      vin[0] = px; vin[1] = yl; vin[2] = pz; vin[3] = ONE;
    end else begin
      vin = vout;
    end
  end

  // Product of the registered vector element and the memory word.
  always_ff @(posedge clk) begin
    if (cmd.mac_mul) v_el <= vin[cmd.vsel];
  end
  assign m_el = fit(mem_q);
  assign prod_full = PW'(v_el) * PW'(m_el);
  assign prod_sh = (prod_full < 0) ? -((-prod_full) >>> FRAC_BITS) : (prod_full >>> FRAC_BITS);
  always_comb begin
    if (prod_sh > PW'(WMAX)) prod_sat = WMAX;
    else if (prod_sh < PW'(WMIN)) prod_sat = WMIN;
    else prod_sat = W'(prod_sh);
  end

  // Accumulator with saturation at column end.
  always_ff @(posedge clk) begin
    if (cmd.mac_clr) acc <= '0;
    else if (cmd.mac_en) acc <= acc + SW'(prod_sat);
  end
  always_comb begin
    if (acc > SW'(WMAX)) acc_sat = WMAX;
    else if (acc < SW'(WMIN)) acc_sat = WMIN;
    else acc_sat = W'(acc);
  end

  // Request capture and column store.
  logic signed [W-1:0] clip [4];
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px <= fit(pos_x); py <= fit(pos_y); pz <= fit(pos_z); play <= in_play;
    end
    if (cmd.col_st) begin
      if (cmd.proj) clip[cmd.csel] <= acc_sat;
      else vout[cmd.csel] <= acc_sat;
    end
  end

  assign sts.w_ok = play && (clip[3] > THR);

  // Restoring divider, one quotient bit per cycle.
  logic [DW-1:0] dq, dr;
  logic [W-1:0]  dd;
  logic [CW-1:0] dcnt;
  logic          dbusy, dneg;
  logic [DW:0]   dtrial;
  logic [W-1:0]  dn_mag;
  logic signed [W-1:0] dnum;
  logic [DW-1:0] dlim, dmag;
  logic signed [W-1:0] dres;
  logic [DW-1:0] dn_sh;

  assign dnum = cmd.div_y ? clip[1] : clip[0];
  assign dn_mag = dnum[W-1] ? W'(-dnum) : W'(dnum);
  assign dn_sh = DW'(dn_mag) << FRAC_BITS;
  assign dtrial = {dr, dq[DW-1]} - (DW+1)'(dd);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt <= '0;
    end else if (cmd.div_go) begin
      dbusy <= 1'b1;
      dcnt <= CW'(DW);
    end else if (dbusy) begin
      dcnt <= dcnt - CW'(1);
      if (dcnt == CW'(1)) dbusy <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dq <= dn_sh;
      dr <= '0;
      dd <= W'(clip[3]);
      dneg <= dnum[W-1];
    end else if (dbusy) begin
      if (!dtrial[DW]) begin
        dr <= dtrial[DW-1:0];
        dq <= {dq[DW-2:0], 1'b1};
      end else begin
        dr <= {dr[DW-2:0], dq[DW-1]};
        dq <= {dq[DW-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = dbusy && (dcnt == CW'(1)) ? 1'b0 : (!dbusy && !cmd.div_go);

  // Saturate the quotient and apply the sign.
  assign dlim = dneg ? DW'(WMAX) + DW'(1) : DW'(WMAX);
  assign dmag = (dq > dlim) ? dlim : dq;
  assign dres = dneg ? W'(-dmag) : W'(dmag);

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.div_st) begin
      case ({cmd.head, cmd.div_y})
        2'b00: res_fx <= to32(dres);
        2'b01: res_fy <= to32(dres);
        2'b10: res_hx <= to32(dres);
        2'b11: res_hy <= to32(dres);
        default: res_fx <= to32(dres);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (cmd.start) res_valid <= 1'b0;
    else if (cmd.div_st && cmd.head && cmd.div_y) res_valid <= 1'b1;
  end
endmodule

FILE: hdl/point_view_projection_anchor.sv
// Top level of the point projection anchor.
// A load request writes one matrix word. A project request runs two points, each
// through 32 multiply-accumulate steps of the shared multiplier and two divisions on
// the serial divider; a point whose clip w fails the threshold, or play not active,
// skips the rest of the work and ends sooner. The result sits in an output register,
// and the next request is taken once it has moved on.
module point_view_projection_anchor #(
  parameter int FRAC_BITS  = pvpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = pvpa_pkg::WORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  pvpa_if.sink                           in_ch,
  pvpa_if.source                         out_ch,
  input  logic                           cfg_we,
  input  logic [pvpa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pvpa_pkg::IO_W-1:0]      cfg_data
);
  import pvpa_pkg::*;

  pvpa_cmd_t cmd;
  pvpa_sts_t sts;
  logic busy, acc_in, res_valid, ov;
  logic [IO_W-1:0] fx, fy, hx, hy;

  assign in_ch.ready = !busy && !ov;
  assign acc_in = in_ch.valid && in_ch.ready;

  pvpa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .go(acc_in && in_ch.data.command == CMD_PROJECT),
    .out_free(!ov), .sts(sts), .cmd(cmd), .busy(busy)
  );

  pvpa_dp #(.FRAC_BITS(FRAC_BITS), .WORD_WIDTH(WORD_WIDTH)) u_dp (
    .clk(clk), .rst(rst),
    .ld_en(acc_in && in_ch.data.command == CMD_LOAD),
    .ld_idx(in_ch.data.matrix_index), .ld_word(in_ch.data.matrix_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_play(in_ch.data.in_play),
    .pos_x(in_ch.data.pos_x), .pos_y(in_ch.data.pos_y), .pos_z(in_ch.data.pos_z),
    .cmd(cmd), .sts(sts), .res_valid(res_valid),
    .res_fx(fx), .res_fy(fy), .res_hx(hx), .res_hy(hy)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (cmd.fin) ov <= 1'b1;
    else if (out_ch.ready) ov <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_ch.data.anchor_valid <= res_valid;
      out_ch.data.feet_x <= res_valid ? fx : '0;
      out_ch.data.feet_y <= res_valid ? fy : '0;
      out_ch.data.head_x <= res_valid ? hx : '0;
      out_ch.data.head_y <= res_valid ? hy : '0;
    end
  end
  assign out_ch.valid = ov;
endmodule

FILE: hdl/pvpa_chk.sv
// Port-level checker for the point projection anchor, bound to the top level.
module pvpa_chk (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic anchor_valid,
  input logic [31:0] feet_x
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !anchor_valid |-> feet_x == 32'd0) else $error("invalid result not zero");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("request taken over full output");
endmodule

bind point_view_projection_anchor pvpa_chk u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .anchor_valid(out_ch.data.anchor_valid), .feet_x(out_ch.data.feet_x)
);

FILE: bench/pvpa_tb_pkg.sv
// Request and result payload types shared by the bench top and its checker.
`timescale 1ns / 100ps
package pvpa_tb_pkg;

  typedef struct packed {
    logic        command;
    logic        in_play;
    logic [4:0]  matrix_index;
    logic [31:0] matrix_word;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
  } pvpa_req_t;

  typedef struct packed {
    logic        anchor_valid;
    logic [31:0] feet_x;
    logic [31:0] feet_y;
    logic [31:0] head_x;
    logic [31:0] head_y;
  } pvpa_res_t;

endpackage

FILE: bench/pvpa_checker.sv
// Checker that predicts every anchor result and compares it with the block's output.
`timescale 1ns / 100ps
module pvpa_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  pvpa_tb_pkg::pvpa_req_t    in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  pvpa_tb_pkg::pvpa_res_t    out_data,
  input  logic                      cfg_we,
  input  logic [pvpa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [pvpa_pkg::IO_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import pvpa_pkg::*;
  import pvpa_tb_pkg::*;

  localparam int FB = 16;

  longint    matrix_copy [32];
  longint    feet_ofs;
  longint    head_ofs;
  pvpa_res_t anchor_queue [$];

  // Clamp to the signed 32-bit word range.
  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed-point product, truncated toward zero.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    if (p < 0) return sat_word(-((-p) >>> FB));
    return sat_word(p >>> FB);
  endfunction

  // Fixed-point quotient, truncated toward zero.
  function automatic longint fx_div(longint n, longint d);
    return sat_word((n <<< FB) / d);
  endfunction

  // Row vector times one stored 4x4 matrix.
  function automatic void vec_mat(input longint v [4], input int base, output longint o [4]);
    longint acc;
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      for (int r = 0; r < 4; r++) acc += fx_mul(v[r], matrix_copy[(base + r * 4 + c) % 32]);
      o[c] = sat_word(acc);
    end
  endfunction

  // Projects one lifted point; returns whether clip w passes the threshold.
  function automatic bit screen_point(longint x, longint y, longint z,
                                      output longint sx, output longint sy);
    longint v [4];
    longint e [4];
    longint clip [4];
    v[0] = x; v[1] = y; v[2] = z; v[3] = longint'(1) <<< FB;
    vec_mat(v, 0, e);
    vec_mat(e, 16, clip);
    sx = 0;
    sy = 0;
    if (clip[3] <= (longint'(1) <<< FB) / THRESH_DIV) return 1'b0;
    sx = fx_div(clip[0], clip[3]);
    sy = fx_div(clip[1], clip[3]);
    return 1'b1;
  endfunction

  function automatic pvpa_res_t predict_anchor(pvpa_req_t rq);
    pvpa_res_t res;
    longint    x, y, z, fx, fy, hx, hy;
    bit        ok;
    res = '0;
    ok = rq.in_play;
    if (ok) begin
      x = longint'(signed'(rq.pos_x));
      y = longint'(signed'(rq.pos_y));
      z = longint'(signed'(rq.pos_z));
      ok = screen_point(x, sat_word(y + feet_ofs), z, fx, fy);
      if (ok) ok = screen_point(x, sat_word(y + head_ofs), z, hx, hy);
    end
    if (ok) begin
      res.anchor_valid = 1'b1;
      res.feet_x = fx[31:0];
      res.feet_y = fy[31:0];
      res.head_x = hx[31:0];
      res.head_y = hy[31:0];
    end
    return res;
  endfunction

  // Compares one field of a result.
  function automatic void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
      fail_count++;
    end
  endfunction

  assign pending = anchor_queue.size();

  // Track configuration, requests and results at each rising edge.
  always @(posedge clk) begin
    pvpa_res_t want;
    if (rst) begin
      feet_ofs = 0;
      head_ofs = longint'(9) <<< FB;
      fail_count = 0;
      anchor_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_FEET) feet_ofs = longint'(signed'(cfg_data));
        else if (cfg_idx == REG_HEAD) head_ofs = longint'(signed'(cfg_data));
      end
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_LOAD)
          matrix_copy[in_data.matrix_index] = longint'(signed'(in_data.matrix_word));
        else
          anchor_queue.insert(anchor_queue.size(), predict_anchor(in_data));
      end
      if (out_valid && out_ready) begin
        if (anchor_queue.size() == 0) begin
          $error("unexpected result with no request waiting");
          fail_count++;
        end else begin
          want = anchor_queue.pop_front();
          cmp_field("anchor_valid", 32'(want.anchor_valid), 32'(out_data.anchor_valid));
          cmp_field("feet_x", want.feet_x, out_data.feet_x);
          cmp_field("feet_y", want.feet_y, out_data.feet_y);
          cmp_field("head_x", want.head_x, out_data.head_x);
          cmp_field("head_y", want.head_y, out_data.head_y);
        end
      end
    end
  end

endmodule

FILE: bench/point_view_projection_anchor_tb.sv
// Stimulus and verdict for the point projection anchor.
`timescale 1ns / 100ps
module point_view_projection_anchor_tb;
  import pvpa_pkg::*;
  import pvpa_tb_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 600;
  localparam int ONE        = 1 << 16;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [IO_W-1:0] cfg_data;
  int   fail_count;
  int   pending;
  int   send_pct;
  int   recv_pct;
  bit   hold_go;

  pvpa_if #(.payload_t(pvpa_req_t)) in_ch (clk);
  pvpa_if #(.payload_t(pvpa_res_t)) out_ch (clk);

  point_view_projection_anchor uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  pvpa_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // Ends the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_req(pvpa_req_t rq);
    if ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until every expected result has come, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_offsets(logic [31:0] feet, logic [31:0] head);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_FEET;
    cfg_data <= feet;
    @(posedge clk);
    cfg_idx  <= REG_HEAD;
    cfg_data <= head;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic pvpa_req_t load_req(int idx, logic [31:0] w);
    pvpa_req_t rq;
    rq = '0;
    rq.command      = CMD_LOAD;
    rq.matrix_index = idx[4:0];
    rq.matrix_word  = w;
    rq.in_play      = 1'($urandom_range(1));
    rq.pos_x        = $urandom;
    return rq;
  endfunction

  function automatic pvpa_req_t proj_req(logic play, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z);
    pvpa_req_t rq;
    rq.command      = CMD_PROJECT;
    rq.in_play      = play;
    rq.matrix_index = 5'($urandom);
    rq.matrix_word  = $urandom;
    rq.pos_x        = x;
    rq.pos_y        = y;
    rq.pos_z        = z;
    return rq;
  endfunction

  // Mostly small values so that projections stay meaningful, sometimes full range.
  function automatic logic [31:0] rand_val(int small_span);
    if ($urandom_range(4) == 0) return $urandom;
    return 32'($signed($urandom_range(2 * small_span)) - small_span);
  endfunction

  function automatic pvpa_req_t rand_req();
    if ($urandom_range(1) == 0) begin
      if ($urandom_range(3) == 0)
        return load_req($urandom_range(31), ONE + rand_val(ONE / 4));
      return load_req($urandom_range(31), rand_val(2 * ONE));
    end
    return proj_req($urandom_range(9) != 0, rand_val(64 * ONE), rand_val(64 * ONE),
                    rand_val(64 * ONE));
  endfunction

  task automatic run_random(int count);
    repeat (count) send_req(rand_req());
  endtask

  // Identity view and a simple perspective projection with w taken from z.
  task automatic load_camera();
    for (int i = 0; i < 32; i++)
      send_req(load_req(i, (i % 16 == i / 4 % 4 * 5 && i != 31) ? ONE : 0));
    send_req(load_req(27, ONE));
    send_req(load_req(31, 0));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_pct = 0;
    recv_pct = 0;
    hold_go = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset offsets and a known camera.
    write_offsets(32'd0, 32'(9 * ONE));
    load_camera();
    send_req(proj_req(1'b1, 32'(2 * ONE), 32'(ONE), 32'(5 * ONE)));
    send_req(proj_req(1'b0, 32'(2 * ONE), 32'(ONE), 32'(5 * ONE)));
    send_req(proj_req(1'b1, 32'(ONE), 32'(ONE), 32'd0));
    send_req(proj_req(1'b1, 32'(ONE), 32'(ONE), 32'd7));
    send_req(proj_req(1'b1, 32'(ONE), 32'(ONE), 32'd6));
    send_req(proj_req(1'b1, 32'(ONE), 32'(ONE), -32'(3 * ONE)));
    send_req(proj_req(1'b1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_req(proj_req(1'b1, 32'h80000000, 32'h80000000, 32'h7fffffff));
    send_req(proj_req(1'b1, 32'h7fffffff, 32'h80000000, 32'd8));
    send_req(load_req(0, 32'h7fffffff));
    send_req(load_req(21, 32'h80000000));
    send_req(proj_req(1'b1, 32'h80000000, 32'h7fffffff, 32'(ONE)));
    send_req(proj_req(1'b1, 32'hffffffff, 32'h00000001, 32'h7fffffff));
    drain();

    // Sender seldom idles, receiver mostly stalls; one long hold-off first.
    write_offsets(rand_val(4 * ONE), rand_val(16 * ONE));
    send_pct = 17;
    recv_pct = 83;
    hold_go = 1'b1;
    run_random(380);
    drain();

    // The other way round, with the offset extremes.
    write_offsets(32'h80000000, 32'h7fffffff);
    send_pct = 83;
    recv_pct = 17;
    run_random(380);
    drain();

    // No idling on either side.
    write_offsets(32'h7fffffff, 32'h80000000);
    send_pct = 0;
    recv_pct = 0;
    run_random(200);
    drain();
    write_offsets(rand_val(ONE), rand_val(ONE));
    run_random(190);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
